// ===== design/seqrob_pkg.sv =====
`timescale 1ns / 1ps

package seqrob_pkg;

  // Field widths fixed by the item format.
  localparam int CHAN_W = 2;
  localparam int SEQ_W  = 32;
  localparam int PAY_W  = 64;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 6;

  localparam logic [CFG_W-1:0] MIN_RELEASE_RESET = 6'd8;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_RELEASED = 2'd0;
  localparam logic [STAT_W-1:0] ST_LATE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFSET,
    S_CHECK,
    S_DROP,
    S_COUNT,
    S_READ,
    S_EMIT
  } seqrob_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic calc_off;
    logic store;
    logic count_init;
    logic count_step;
    logic rd_issue;
    logic emit_drop;
    logic emit_rel;
  } seqrob_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drop;
    logic count_more;
    logic release_ok;
    logic rel_last;
    logic out_free;
  } seqrob_stat_t;

endpackage

// ===== design/seqrob_in_if.sv =====
`timescale 1ns / 1ps

interface seqrob_in_if import seqrob_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [SEQ_W-1:0]  seq_id;
  logic [PAY_W-1:0]  payload;

  modport source (output valid, output channel, output seq_id, output payload, input ready);
  modport sink   (input valid, input channel, input seq_id, input payload, output ready);
endinterface

// ===== design/seqrob_out_if.sv =====
`timescale 1ns / 1ps

interface seqrob_out_if import seqrob_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_channel;
  logic [SEQ_W-1:0]  out_seq;
  logic [PAY_W-1:0]  out_payload;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, output out_channel, output out_seq, output out_payload,
                  output status, output last, input ready);
  modport sink   (input valid, input out_channel, input out_seq, input out_payload,
                  input status, input last, output ready);
endinterface

// ===== design/seqrob_cfg_if.sv =====
`timescale 1ns / 1ps

interface seqrob_cfg_if import seqrob_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] min_release;

  modport source (output valid, output min_release, input ready);
  modport sink   (input valid, input min_release, output ready);
endinterface

// ===== design/seqrob_ctrl.sv =====
`timescale 1ns / 1ps

module seqrob_ctrl import seqrob_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  seqrob_stat_t st,
  output seqrob_cmd_t  cmd
);

  seqrob_state_t state;
  seqrob_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_OFFSET;
      end
      S_OFFSET: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = st.drop ? S_DROP : S_COUNT;
      end
      S_DROP: begin
        if (st.out_free) state_next = S_IDLE;
      end
      S_COUNT: begin
        if (!st.count_more) state_next = st.release_ok ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) state_next = st.rel_last ? S_IDLE : S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_OFFSET: begin
        cmd.calc_off = 1'b1;
      end
      S_CHECK: begin
        cmd.store      = !st.drop;
        cmd.count_init = !st.drop;
      end
      S_DROP: begin
        cmd.emit_drop = st.out_free;
      end
      S_COUNT: begin
        cmd.count_step = st.count_more;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
      end
      S_EMIT: begin
        cmd.emit_rel = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/seqrob_dp.sv =====
`timescale 1ns / 1ps

module seqrob_dp import seqrob_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  seqrob_cmd_t       cmd,
  output seqrob_stat_t      st,
  input  logic [CHAN_W-1:0] channel,
  input  logic [SEQ_W-1:0]  seq_id,
  input  logic [PAY_W-1:0]  payload,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAN_W-1:0] out_channel,
  output logic [SEQ_W-1:0]  out_seq,
  output logic [PAY_W-1:0]  out_payload,
  output logic [STAT_W-1:0] status,
  output logic              last
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SL_W  = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AD_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SL_W:0]  WIN_S   = (SL_W + 1)'(WINDOW);
  localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WINDOW);
  localparam logic [6:0]     WIN_7   = 7'(WINDOW);
  localparam logic [6:0]     CHANS_7 = 7'(CHANNELS);

  // Item being worked on.
  logic [CHAN_W-1:0] req_channel;
  logic [SEQ_W-1:0]  req_seq;
  logic [PAY_W-1:0]  req_payload;
  logic              req_ch_ok;
  logic [SL_W-1:0]   off_reg;
  logic              late;
  logic              beyond;

  // Per-channel window state. Slots are addressed relative to a rotating base.
  logic [SEQ_W-1:0]  exp_seq [CHANNELS];
  logic [SL_W-1:0]   base    [CHANNELS];
  logic [WINDOW-1:0] present [CHANNELS];
  logic [PAY_W-1:0]  mem     [DEPTH];
  logic [PAY_W-1:0]  rd_data;

  logic [CNT_W-1:0]  cnt;
  logic [SL_W-1:0]   ptr;
  logic [CFG_W-1:0]  min_release;

  logic [CH_W-1:0]   ch_sel;
  logic [SEQ_W-1:0]  off;
  logic [SL_W-1:0]   slot;
  logic [AD_W-1:0]   wr_addr;
  logic [AD_W-1:0]   rd_addr;
  logic [6:0]        thr7;
  logic [CNT_W-1:0]  thr;
  logic              in_ch_ok;

  function automatic logic [SL_W-1:0] wrap_add(input logic [SL_W-1:0] a,
                                               input logic [SL_W-1:0] b);
    logic [SL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WIN_S) s = s - WIN_S;
    return s[SL_W-1:0];
  endfunction

  function automatic logic [AD_W-1:0] addr_of(input logic [CH_W-1:0] c,
                                              input logic [SL_W-1:0] s);
    return AD_W'(int'(c) * WINDOW + int'(s));
  endfunction

  assign in_ch_ok = ({5'd0, channel} < CHANS_7);
  assign ch_sel   = req_ch_ok ? CH_W'(req_channel) : '0;
  assign off      = req_seq - exp_seq[ch_sel];
  assign slot     = wrap_add(base[ch_sel], off_reg);
  assign wr_addr  = addr_of(ch_sel, slot);
  assign rd_addr  = addr_of(ch_sel, base[ch_sel]);

  // A threshold of zero acts as one, and anything above the window as a full window.
  always_comb begin
    thr7 = {1'b0, min_release};
    if (thr7 == 7'd0) thr7 = 7'd1;
    if (thr7 > WIN_7) thr7 = WIN_7;
    thr = CNT_W'(thr7);
  end

  assign st.drop       = late | beyond | present[ch_sel][slot];
  assign st.count_more = (cnt < WIN_C) & present[ch_sel][ptr];
  assign st.release_ok = (cnt >= thr);
  assign st.rel_last   = (cnt == CNT_W'(1));
  assign st.out_free   = !out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_channel <= channel;
      req_seq     <= seq_id;
      req_payload <= payload;
      req_ch_ok   <= in_ch_ok;
    end
    if (cmd.calc_off) begin
      off_reg <= off[SL_W-1:0];
      late    <= req_ch_ok & off[SEQ_W-1];
      beyond  <= !req_ch_ok | (!off[SEQ_W-1] & (off[SEQ_W-2:0] >= (SEQ_W - 1)'(WINDOW)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) mem[wr_addr] <= req_payload;
    if (cmd.rd_issue) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        exp_seq[c] <= SEQ_W'(1);
        base[c]    <= '0;
        present[c] <= '0;
      end
      cnt         <= '0;
      ptr         <= '0;
      min_release <= MIN_RELEASE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) min_release <= cfg_data;
      if (cmd.store) present[ch_sel][slot] <= 1'b1;
      if (cmd.count_init) begin
        cnt <= '0;
        ptr <= base[ch_sel];
      end else if (cmd.count_step) begin
        cnt <= cnt + CNT_W'(1);
        ptr <= wrap_add(ptr, SL_W'(1));
      end else if (cmd.emit_rel) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (cmd.emit_rel) begin
        present[ch_sel][base[ch_sel]] <= 1'b0;
        base[ch_sel]    <= wrap_add(base[ch_sel], SL_W'(1));
        exp_seq[ch_sel] <= exp_seq[ch_sel] + SEQ_W'(1);
      end
      if (cmd.emit_rel || cmd.emit_drop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_drop) begin
      out_channel <= req_channel;
      out_seq     <= req_seq;
      out_payload <= req_payload;
      status      <= beyond ? ST_BEYOND : ST_LATE;
      last        <= 1'b1;
    end else if (cmd.emit_rel) begin
      out_channel <= req_channel;
      out_seq     <= exp_seq[ch_sel];
      out_payload <= rd_data;
      status      <= ST_RELEASED;
      last        <= st.rel_last;
    end
  end

endmodule

// ===== design/sequence_reorder_buffer.sv =====
// Items are handled one at a time. A dropped item passes the offset, check and drop
// states after its request is taken; the drop state waits until the output register is free.
// A stored item that is held walks its present run one slot a cycle, and a released run
// is walked, then each item takes one payload memory read and one output load.
// Reset (rst, synchronous, active high) sets every expected sequence to 1, all window
// bases to 0 and clears all presence bits at once; the payload memory is not cleared.
`timescale 1ns / 1ps

module sequence_reorder_buffer import seqrob_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 32
) (
  input  logic  clk,
  input  logic  rst,
  seqrob_in_if.sink    items,
  seqrob_out_if.source results,
  seqrob_cfg_if.sink   cfg
);

  // The controller sequences each item through offset computation, the window
  // check, the run walk and the release loop. The datapath holds the per-channel
  // expected sequence numbers, rotating window bases, presence bits, the payload
  // memory and the output register.
  seqrob_cmd_t  cmd;
  seqrob_stat_t st;

  // Writes are always taken, unchecked; the user must see writes are made only while idle.
  assign cfg.ready = 1'b1;

  seqrob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The output register decouples the sides: a new input request is taken while
  // a finished result still waits for its request to be accepted downstream.
  seqrob_dp #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .channel     (items.channel),
    .seq_id      (items.seq_id),
    .payload     (items.payload),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.min_release),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_channel (results.out_channel),
    .out_seq     (results.out_seq),
    .out_payload (results.out_payload),
    .status      (results.status),
    .last        (results.last)
  );

endmodule

// ===== design/seqrob_chk.sv =====
`timescale 1ns / 1ps

module seqrob_chk import seqrob_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] status,
  input logic              last
);

  // A pending result request is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request withdrawn before it was taken");

  // A dropped item always produces exactly one result, marked last.
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RELEASED |-> last)
    else $error("dropped item result without last");

  // Items are worked one at a time: after a request is taken the input side closes.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a request");

  // While a release run is still being delivered, no new item is taken.
  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && status == ST_RELEASED && !last |-> !in_ready)
    else $error("input open in the middle of a release run");

endmodule

bind sequence_reorder_buffer seqrob_chk u_seqrob_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .status    (results.status),
  .last      (results.last)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import seqrob_pkg::*;

  localparam int CHANS           = 4;
  localparam int WIN             = 32;
  localparam int HOLD_OFF_CYCLES = 50;
  localparam int LONG_STALL      = 300;
  localparam int LIMIT_NS        = 500_000;

  // Two copies of the resequencer state: one follows the block request by
  // request, the other runs ahead while stimulus is planned.
  localparam int LIVE = 0;
  localparam int PLAN = 1;

  typedef struct {
    logic [CHAN_W-1:0] chan;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  pay;
  } rob_item_t;

  typedef struct {
    logic [CHAN_W-1:0] chan;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  pay;
    logic [STAT_W-1:0] status;
    logic              last;
  } rob_result_t;

  logic clk = 1'b0;
  logic rst;

  seqrob_in_if  items_if ();
  seqrob_out_if results_if ();
  seqrob_cfg_if cfg_if ();

  sequence_reorder_buffer #(
    .CHANNELS(CHANS),
    .WINDOW  (WIN)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .results(results_if),
    .cfg    (cfg_if)
  );

  always #1 clk = ~clk;

  // Resequencer state, per copy.
  logic [SEQ_W-1:0] next_seq  [2][CHANS];
  bit               slot_full [2][CHANS][WIN];
  logic [PAY_W-1:0] slot_data [2][CHANS][WIN];
  logic [CFG_W-1:0] min_rel   [2];

  rob_item_t   pending_q [$];
  rob_result_t due_results [$];

  int planned        = 0;
  int accepted_count = 0;
  int fail_count     = 0;
  int src_idle_pct   = 10;
  int snk_idle_pct   = 53;
  bit src_pause      = 1'b0;
  int stall_requests = 0;

  function automatic void reset_model(input int cp);
    int c, s;
    min_rel[cp] = MIN_RELEASE_RESET;
    for (c = 0; c < CHANS; c++) begin
      next_seq[cp][c] = 32'd1;
      for (s = 0; s < WIN; s++) begin
        slot_full[cp][c][s] = 1'b0;
        slot_data[cp][c][s] = '0;
      end
    end
  endfunction

  function automatic void note_result(input int cp, input logic [CHAN_W-1:0] ch,
                                      input logic [SEQ_W-1:0] seq,
                                      input logic [PAY_W-1:0] pay,
                                      input logic [STAT_W-1:0] st, input logic lst);
    rob_result_t r;
    r.chan   = ch;
    r.seq    = seq;
    r.pay    = pay;
    r.status = st;
    r.last   = lst;
    if (cp == LIVE) due_results.push_back(r);
  endfunction

  // Drops a late, duplicate or out-of-window item; else stores it in its channel window
  // and releases the run at the head of the window once it is long enough.
  function automatic void resequence(input int cp, input logic [CHAN_W-1:0] ch,
                                     input logic [SEQ_W-1:0] seq,
                                     input logic [PAY_W-1:0] pay);
    logic [SEQ_W-1:0] off;
    int run, thr, i;
    off = seq - next_seq[cp][ch];
    // Behind the expected number, or a slot that already holds an item.
    if (off[31] || (off < WIN && slot_full[cp][ch][off[4:0]])) begin
      note_result(cp, ch, seq, pay, ST_LATE, 1'b1);
      return;
    end
    if (off >= WIN) begin
      note_result(cp, ch, seq, pay, ST_BEYOND, 1'b1);
      return;
    end
    slot_full[cp][ch][off[4:0]] = 1'b1;
    slot_data[cp][ch][off[4:0]] = pay;
    run = 0;
    while (run < WIN && slot_full[cp][ch][run]) run++;
    // A threshold of zero acts as one; anything above the window acts as a full window.
    thr = (min_rel[cp] == 0) ? 1 : ((min_rel[cp] > WIN) ? WIN : int'(min_rel[cp]));
    if (run < thr) return;
    for (i = 0; i < run; i++)
      note_result(cp, ch, next_seq[cp][ch] + i, slot_data[cp][ch][i], ST_RELEASED,
                  i == run - 1);
    for (i = 0; i < WIN; i++) begin
      if (i + run < WIN) begin
        slot_full[cp][ch][i] = slot_full[cp][ch][i + run];
        slot_data[cp][ch][i] = slot_data[cp][ch][i + run];
      end else begin
        slot_full[cp][ch][i] = 1'b0;
        slot_data[cp][ch][i] = '0;
      end
    end
    next_seq[cp][ch] = next_seq[cp][ch] + run;
  endfunction

  function automatic void add_item(input logic [CHAN_W-1:0] ch, input logic [SEQ_W-1:0] seq,
                                   input logic [PAY_W-1:0] pay);
    rob_item_t it;
    it.chan = ch;
    it.seq  = seq;
    it.pay  = pay;
    pending_q.push_back(it);
    resequence(PLAN, ch, seq, pay);
    planned++;
  endfunction

  // Mostly bursts of consecutive numbers in shuffled order, some with a hole
  // left or the head held back to the end; the rest are items to be dropped.
  // A burst is cut short once the requested number of items is planned.
  task automatic plan_random(input int count);
    int stop, kind, n, k, j, first;
    logic [CHAN_W-1:0] ch;
    logic [SEQ_W-1:0] base, tmp;
    logic [SEQ_W-1:0] seqs [$];
    stop = planned + count;
    while (planned < stop) begin
      ch   = CHAN_W'($urandom_range(CHANS - 1));
      base = next_seq[PLAN][ch];
      kind = $urandom_range(99);
      if (kind < 75) begin
        n = $urandom_range(12, 1);
        if ($urandom_range(3) == 0 || (min_rel[PLAN] > 16 && $urandom_range(1) == 1))
          n = WIN;
        first = (kind >= 15 && kind < 30) ? 1 : 0;
        seqs.delete();
        for (k = first; k < n; k++)
          if (!slot_full[PLAN][ch][k]) seqs.push_back(base + k);
        for (k = seqs.size() - 1; k > 0; k--) begin
          j       = $urandom_range(k);
          tmp     = seqs[k];
          seqs[k] = seqs[j];
          seqs[j] = tmp;
        end
        if (kind < 15 && seqs.size() > 1)
          seqs.delete($urandom_range(seqs.size() - 1));
        else if (first == 1 && !slot_full[PLAN][ch][0])
          seqs.push_back(base);
        foreach (seqs[k])
          if (planned < stop) add_item(ch, seqs[k], {$urandom, $urandom});
      end else begin
        if (kind < 81) begin
          tmp = base - 32'd1 - 32'($urandom_range(40));
        end else if (kind < 88) begin
          k   = $urandom_range(WIN - 1);
          tmp = slot_full[PLAN][ch][k] ? base + k : base - 32'd1;
        end else if (kind < 95) begin
          tmp = base + WIN + $urandom_range(32'h7FFF_FFDF);
        end else begin
          tmp = base + 32'h8000_0000 + $urandom_range(32'h7FFF_FFFF);
        end
        add_item(ch, tmp, {$urandom, $urandom});
      end
    end
  endtask

  task automatic write_min_release(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.min_release <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    min_rel[LIVE] = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Waits until every request is taken and answered, then lets a held item
  // finish its walk through the window.
  task automatic wait_drained;
    while (pending_q.size() != 0 || items_if.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_items
    rob_item_t nxt;
    if (rst) begin
      items_if.valid <= 1'b0;
    end else begin
      if (items_if.valid && items_if.ready) begin
        resequence(LIVE, items_if.channel, items_if.seq_id, items_if.payload);
        accepted_count++;
      end
      if (!items_if.valid || items_if.ready) begin
        if (pending_q.size() != 0 && !src_pause && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_q.pop_front();
          items_if.channel <= nxt.chan;
          items_if.seq_id  <= nxt.seq;
          items_if.payload <= nxt.pay;
          items_if.valid   <= 1'b1;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    rob_result_t want;
    int stall_served;
    int stall_left;
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_served = 0;
      stall_left   = 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ch %0d seq %h pay %h st %0d last %b",
                   $time, results_if.out_channel, results_if.out_seq,
                   results_if.out_payload, results_if.status, results_if.last);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("out_channel", 64'(want.chan), 64'(results_if.out_channel));
          check_field("out_seq", 64'(want.seq), 64'(results_if.out_seq));
          check_field("out_payload", want.pay, results_if.out_payload);
          check_field("status", 64'(want.status), 64'(results_if.status));
          check_field("last", 64'(want.last), 64'(results_if.last));
        end
      end
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        stall_left   = LONG_STALL;
      end
      if (stall_left != 0) begin
        stall_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("** sequence_reorder_buffer: FAILED **");
    $finish;
  end

  initial begin
    int mark;
    rst                = 1'b1;
    items_if.valid     = 1'b0;
    items_if.channel   = '0;
    items_if.seq_id    = '0;
    items_if.payload   = '0;
    results_if.ready   = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.min_release = '0;
    reset_model(LIVE);
    reset_model(PLAN);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset threshold: offsets that wrap, the boundary
    // between late and beyond, the last window slot, a duplicate, and a run
    // completed by its head.
    @(negedge clk);
    add_item(2'd0, 32'h0000_0000, 64'h0);
    add_item(2'd0, 32'hFFFF_FFFF, '1);
    add_item(2'd0, 32'h8000_0001, {$urandom, $urandom});
    add_item(2'd0, 32'h8000_0000, {$urandom, $urandom});
    add_item(2'd0, 32'd33, {$urandom, $urandom});
    add_item(2'd0, 32'd32, '1);
    for (int s = 8; s >= 2; s--) add_item(2'd0, 32'(s), {$urandom, $urandom});
    add_item(2'd0, 32'd3, 64'h0);
    add_item(2'd0, 32'd1, 64'h0);
    add_item(2'd1, 32'd1, 64'h0);
    add_item(2'd2, 32'd2, '1);
    add_item(2'd3, 32'd1, {$urandom, $urandom});
    add_item(2'd3, 32'd33, '1);
    add_item(2'd2, 32'd0, {$urandom, $urandom});
    wait_drained();

    // Zero acts as one, so each run releases as soon as its head is stored; the
    // receiver holds off long enough to back the block up.
    write_min_release(6'd0);
    @(negedge clk);
    min_rel[PLAN] = 6'd0;
    mark = accepted_count;
    plan_random(20);
    stall_requests++;
    while (accepted_count < mark + 15) @(negedge clk);
    src_pause = 1'b1;
    while (due_results.size() != 0 || items_if.valid) @(negedge clk);
    src_pause = 1'b0;
    wait_drained();

    src_idle_pct = 53;
    snk_idle_pct = 10;
    write_min_release(6'd63);
    @(negedge clk);
    min_rel[PLAN] = 6'd63;
    plan_random(25);
    wait_drained();

    write_min_release(6'd32);
    @(negedge clk);
    min_rel[PLAN] = 6'd32;
    plan_random(20);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    mark = $urandom_range(31, 2);
    write_min_release(CFG_W'(mark));
    @(negedge clk);
    min_rel[PLAN] = CFG_W'(mark);
    plan_random(20);
    wait_drained();

    write_min_release(6'd1);
    @(negedge clk);
    min_rel[PLAN] = 6'd1;
    plan_random(25);
    wait_drained();

    if (fail_count == 0) begin
      $display("** sequence_reorder_buffer: PASSED **");
    end else begin
      $display("** sequence_reorder_buffer: FAILED **");
    end
    $finish;
  end

endmodule
